// ----- design/humidity_sensor_frame_decoder_unit_defines.svh -----
// Assertion macros shared by the frame decoder modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_UNIT_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define HSFD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define HSFD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define HSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HSFD_ASSERT_ALWAYS(lbl, cond, msg)
`define HSFD_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define HSFD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/hsfd_pkg.sv -----
// Types, constants and the CRC-8 step for the humidity sensor frame decoder.
// No dependencies.
package hsfd_pkg;

	localparam logic [7:0] CRC8_GEN = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam logic [14:0] TEMP_MUL = 15'd17500;
	localparam logic signed [15:0] TEMP_OFS = 16'sd4500;
	localparam logic [13:0] HUM_MUL = 14'd10000;

	localparam logic [2:0] POS_TEMP_HI  = 3'd0;
	localparam logic [2:0] POS_TEMP_LO  = 3'd1;
	localparam logic [2:0] POS_TEMP_CRC = 3'd2;
	localparam logic [2:0] POS_HUM_HI   = 3'd3;
	localparam logic [2:0] POS_HUM_LO   = 3'd4;
	localparam logic [2:0] POS_HUM_CRC  = 3'd5;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CW = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_TEMP_BAD = 2'd1,
		STATUS_HUM_BAD  = 2'd2
	} status_t;

	typedef struct packed {
		logic [15:0] raw_temp;
		logic [15:0] raw_hum;
		logic        temp_ok;
		logic        hum_ok;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			v = v[7] ? ({v[6:0], 1'b0} ^ CRC8_GEN) : {v[6:0], 1'b0};
		end
		return v;
	endfunction

endpackage

// ----- design/hsfd_byte_if.sv -----
// Byte request channel into the frame decoder.
// Depends on nothing.
interface hsfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ----- design/hsfd_res_if.sv -----
// Result request channel out of the frame decoder.
// Depends on nothing.
interface hsfd_res_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] temp_centi;
	logic [13:0]        hum_centi;
	logic [15:0]        raw_temp;
	logic [15:0]        raw_hum;
	logic               valid_res;
	logic [1:0]         status;

	modport source (output valid, output temp_centi, output hum_centi, output raw_temp,
		output raw_hum, output valid_res, output status, input ready);
	modport sink (input valid, input temp_centi, input hum_centi, input raw_temp,
		input raw_hum, input valid_res, input status, output ready);
endinterface

// ----- design/hsfd_frame_front.sv -----
// Front part: accepts bytes, tracks frame position, runs CRC-8 and builds frame records.
// Depends on hsfd_pkg, hsfd_byte_if and the defines header.
`include "humidity_sensor_frame_decoder_unit_defines.svh"

module hsfd_frame_front import hsfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	hsfd_byte_if.sink          rx,
	input  q_stat_t            q_stat,
	output logic               push,
	output frame_rec_t         push_rec
);

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_word_q;
	logic [15:0] hum_word_q;
	logic        temp_ok_q;

	logic        take;
	logic [2:0]  pos;
	logic [7:0]  crc_base;
	logic [7:0]  crc_next;

	assign rx.ready = !q_stat.full;
	assign take = rx.valid && rx.ready;

	always_comb begin
		pos = (rx.frame_start || pos_q > POS_HUM_CRC) ? POS_TEMP_HI : pos_q;
		crc_base = (pos == POS_TEMP_HI || pos == POS_HUM_HI) ? CRC_INIT : crc_q;
		crc_next = crc8_byte(crc_base, rx.rx_byte);
	end

	assign push = take && (pos == POS_HUM_CRC);
	assign push_rec = '{raw_temp: temp_word_q, raw_hum: hum_word_q,
		temp_ok: temp_ok_q, hum_ok: (crc_q == rx.rx_byte)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_TEMP_HI;
			crc_q       <= CRC_INIT;
			temp_word_q <= '0;
			hum_word_q  <= '0;
			temp_ok_q   <= 1'b0;
		end else if (take) begin
			pos_q <= (pos == POS_HUM_CRC) ? POS_TEMP_HI : pos + 3'd1;
			case (pos)
				POS_TEMP_HI: begin
					temp_word_q[15:8] <= rx.rx_byte;
					crc_q <= crc_next;
				end
				POS_TEMP_LO: begin
					temp_word_q[7:0] <= rx.rx_byte;
					crc_q <= crc_next;
				end
				POS_TEMP_CRC: begin
					temp_ok_q <= (crc_base == rx.rx_byte);
					crc_q <= CRC_INIT;
				end
				POS_HUM_HI: begin
					hum_word_q[15:8] <= rx.rx_byte;
					crc_q <= crc_next;
				end
				POS_HUM_LO: begin
					hum_word_q[7:0] <= rx.rx_byte;
					crc_q <= crc_next;
				end
				default: begin
					crc_q <= CRC_INIT;
				end
			endcase
		end
	end

	`HSFD_ASSERT_ALWAYS(a_pos_range, pos_q <= POS_HUM_CRC, "frame position beyond last byte")
	`HSFD_ASSERT_IMPLIES(a_push_room, push, !q_stat.full, "frame record pushed into full queue")

endmodule

// ----- design/hsfd_queue.sv -----
// Short queue of completed frame records between the front and back parts.
// Depends on hsfd_pkg and the defines header.
`include "humidity_sensor_frame_decoder_unit_defines.svh"

module hsfd_queue import hsfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_rec_t push_rec,
	input  logic       pop,
	output frame_rec_t head,
	output q_stat_t    q_stat
);

	frame_rec_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0]     wr_ptr_q;
	logic [Q_AW-1:0]     rd_ptr_q;
	logic [Q_CW-1:0]     count_q;

	localparam logic [Q_AW-1:0] PTR_LAST = Q_AW'(Q_DEPTH - 1);
	localparam logic [Q_CW-1:0] CNT_FULL = Q_CW'(Q_DEPTH);

	assign q_stat.full  = (count_q == CNT_FULL);
	assign q_stat.empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`HSFD_ASSERT_IMPLIES(a_no_underflow, pop, !q_stat.empty, "pop from empty queue")
	`HSFD_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_FULL, "queue count beyond depth")

endmodule

// ----- design/hsfd_convert_back.sv -----
// Back part: takes frame records, scales raw words and holds the result register.
// Depends on hsfd_pkg, hsfd_res_if and the defines header.
`include "humidity_sensor_frame_decoder_unit_defines.svh"

module hsfd_convert_back import hsfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  frame_rec_t head,
	input  q_stat_t    q_stat,
	output logic       pop,
	hsfd_res_if.source res
);

	logic               out_v_q;
	logic signed [14:0] temp_centi_q;
	logic [13:0]        hum_centi_q;
	logic [15:0]        raw_temp_q;
	logic [15:0]        raw_hum_q;
	logic               valid_res_q;
	status_t            status_q;

	logic [30:0]        t_prod;
	logic [29:0]        h_prod;
	logic signed [15:0] t_val;
	logic               ok;
	status_t            status_d;

	assign pop = !q_stat.empty && (!out_v_q || res.ready);

	always_comb begin
		t_prod = {16'd0, TEMP_MUL} * {15'd0, head.raw_temp};
		h_prod = {16'd0, HUM_MUL} * {14'd0, head.raw_hum};
		t_val = $signed({1'b0, t_prod[30:16]}) - TEMP_OFS;
		ok = head.temp_ok && head.hum_ok;
		if (!head.temp_ok) begin
			status_d = STATUS_TEMP_BAD;
		end else if (!head.hum_ok) begin
			status_d = STATUS_HUM_BAD;
		end else begin
			status_d = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (pop) begin
			out_v_q <= 1'b1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			temp_centi_q <= ok ? t_val[14:0] : '0;
			hum_centi_q  <= ok ? h_prod[29:16] : '0;
			raw_temp_q   <= head.raw_temp;
			raw_hum_q    <= head.raw_hum;
			valid_res_q  <= ok;
			status_q     <= status_d;
		end
	end

	assign res.valid      = out_v_q;
	assign res.temp_centi = temp_centi_q;
	assign res.hum_centi  = hum_centi_q;
	assign res.raw_temp   = raw_temp_q;
	assign res.raw_hum    = raw_hum_q;
	assign res.valid_res  = valid_res_q;
	assign res.status     = status_q;

	`HSFD_ASSERT_IMPLIES(a_valid_status, out_v_q, valid_res_q == (status_q == STATUS_OK),
		"result flag disagrees with status")

endmodule

// ----- design/humidity_sensor_frame_decoder_unit.sv -----
// Humidity sensor frame decoder, top level: front, record queue and back part.
// Depends on hsfd_pkg, hsfd_byte_if, hsfd_res_if and the three submodules.
//
//   channel  dir  payload                                              handshake
//   rx       in   rx_byte, frame_start                                 valid/ready
//   res      out  temp_centi, hum_centi, raw_temp, raw_hum,            valid/ready
//                 valid_res, status
//
// One byte a cycle while the record queue is not full; the CRC-8 step of a byte is done in the cycle it is accepted.
// After the sixth byte the record is first written into the record queue; from there the
// scaling multipliers feed the result register once it is empty or being read.
// Reset clears frame position, CRC, queue pointers and result valid; no clearing pass.
// The two-entry record queue absorbs result stalls; rx.ready drops only when it is full.
module humidity_sensor_frame_decoder_unit import hsfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	hsfd_byte_if.sink  rx,
	hsfd_res_if.source res
);

	logic       push;
	frame_rec_t push_rec;
	logic       pop;
	frame_rec_t head;
	q_stat_t    q_stat;

	hsfd_frame_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.q_stat   (q_stat),
		.push     (push),
		.push_rec (push_rec)
	);

	hsfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	hsfd_convert_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.res    (res)
	);

endmodule

// ----- dv/hsfd_reading_checker.sv -----
// Watches the byte and result channels of the frame decoder, predicts each reading
// from the accepted bytes and compares it with what the decoder returns.
// Depends on hsfd_pkg, hsfd_byte_if and hsfd_res_if.
module hsfd_reading_checker import hsfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	hsfd_byte_if rx,
	hsfd_res_if  res,
	output int   fail_count,
	output int   pending
);

	typedef struct {
		logic signed [14:0] temp_centi;
		logic [13:0]        hum_centi;
		logic [15:0]        raw_temp;
		logic [15:0]        raw_hum;
		logic               valid_res;
		status_t            status;
	} reading_t;

	reading_t readings_q[$];

	logic [2:0]  frame_pos;
	logic [7:0]  run_crc;
	logic [15:0] t_word;
	logic [15:0] h_word;
	logic        t_ok;

	function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] d);
		logic [7:0] r;
		logic       fb;
		r = c;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ d[i];
			r = {r[6:0], 1'b0};
			if (fb)
				r = r ^ CRC8_GEN;
		end
		return r;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic st);
		logic [2:0] pos;
		logic       h_ok;
		int         tv;
		int         hv;
		reading_t   rd;
		pos = (st || frame_pos > POS_HUM_CRC) ? POS_TEMP_HI : frame_pos;
		if (pos == POS_TEMP_HI || pos == POS_HUM_HI)
			run_crc = CRC_INIT;
		case (pos)
			POS_TEMP_HI: begin
				t_word[15:8] = b;
				run_crc = crc_step(run_crc, b);
			end
			POS_TEMP_LO: begin
				t_word[7:0] = b;
				run_crc = crc_step(run_crc, b);
			end
			POS_TEMP_CRC: begin
				t_ok = (run_crc == b);
				run_crc = CRC_INIT;
			end
			POS_HUM_HI: begin
				h_word[15:8] = b;
				run_crc = crc_step(run_crc, b);
			end
			POS_HUM_LO: begin
				h_word[7:0] = b;
				run_crc = crc_step(run_crc, b);
			end
			default: begin
				h_ok = (run_crc == b);
				tv = 0;
				hv = 0;
				if (t_ok && h_ok) begin
					tv = ((int'(TEMP_MUL) * int'(t_word)) >>> 16) - int'(TEMP_OFS);
					hv = (int'(HUM_MUL) * int'(h_word)) >>> 16;
				end
				rd.temp_centi = tv[14:0];
				rd.hum_centi = hv[13:0];
				rd.raw_temp = t_word;
				rd.raw_hum = h_word;
				rd.valid_res = t_ok && h_ok;
				rd.status = !t_ok ? STATUS_TEMP_BAD : (h_ok ? STATUS_OK : STATUS_HUM_BAD);
				readings_q.push_back(rd);
				run_crc = CRC_INIT;
			end
		endcase
		frame_pos = (pos == POS_HUM_CRC) ? POS_TEMP_HI : pos + 3'd1;
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t rd;
		if (!arst_n) begin
			frame_pos = POS_TEMP_HI;
			run_crc = CRC_INIT;
			t_word = '0;
			h_word = '0;
			t_ok = 1'b0;
			readings_q.delete();
			fail_count = 0;
		end else begin
			if (rx.valid && rx.ready)
				decode_byte(rx.rx_byte, rx.frame_start);
			if (res.valid && res.ready) begin
				if (readings_q.size() == 0) begin
					$error("reading returned with no complete frame outstanding");
					fail_count++;
				end else begin
					rd = readings_q.pop_front();
					check_field("temp_centi", rd.temp_centi, res.temp_centi);
					check_field("hum_centi", rd.hum_centi, res.hum_centi);
					check_field("raw_temp", rd.raw_temp, res.raw_temp);
					check_field("raw_hum", rd.raw_hum, res.raw_hum);
					check_field("valid_res", rd.valid_res, res.valid_res);
					check_field("status", int'(rd.status), res.status);
				end
			end
		end
		pending = readings_q.size();
	end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the humidity sensor frame decoder: clock, reset, byte stimulus,
// result back-pressure and the verdict. Prediction sits in hsfd_reading_checker.
// Depends on hsfd_pkg, both channel interfaces, the decoder and the checker.
module tb_top import hsfd_pkg::*; ();

	localparam int HOLD_CYCLES = 300;
	localparam int RAND_ITEMS  = 1650;
	localparam int TOTAL_ITEMS = 1876;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   sent;
	bit   src_idle;
	bit   snk_idle;
	bit   hold_req;

	hsfd_byte_if rx_ch ();
	hsfd_res_if  res_ch ();

	humidity_sensor_frame_decoder_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	hsfd_reading_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] word_crc(input logic [15:0] w);
		logic [7:0] c;
		c = CRC_INIT;
		for (int i = 15; i >= 0; i--)
			c = (c[7] ^ w[i]) ? ({c[6:0], 1'b0} ^ CRC8_GEN) : {c[6:0], 1'b0};
		return c;
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic st);
		int gap;
		if (src_idle && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		rx_ch.frame_start <= st;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
			input bit bad_t, input bit bad_h, input logic st);
		logic [7:0] ct;
		logic [7:0] ch;
		ct = word_crc(tw);
		ch = word_crc(hw);
		if (bad_t)
			ct = ct ^ 8'($urandom_range(1, 255));
		if (bad_h)
			ch = ch ^ 8'($urandom_range(1, 255));
		send_byte(tw[15:8], st);
		send_byte(tw[7:0], 1'b0);
		send_byte(ct, 1'b0);
		send_byte(hw[15:8], 1'b0);
		send_byte(hw[7:0], 1'b0);
		send_byte(ch, 1'b0);
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (snk_idle && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 6);
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		#400000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		bit aligned;
		bit held;
		int n;
		int waited;
		arst_n = 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		rx_ch.frame_start <= 1'b0;
		sent = 0;
		src_idle = 1'b0;
		snk_idle = 1'b0;
		hold_req = 1'b0;
		held = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, wrap without start, start mid-frame, both and hum-only CRC faults
		send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
		send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		send_byte(8'hA5, 1'b1);
		send_byte(8'h5A, 1'b0);
		send_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b1);
		send_frame(16'h1234, 16'hBEEF, 1'b0, 1'b1, 1'b0);

		src_idle = 1'b1;
		snk_idle = 1'b1;
		aligned = 1'b1;
		while (sent < TOTAL_ITEMS) begin
			if (sent >= RAND_ITEMS) begin
				src_idle = 1'b0;
				snk_idle = 1'b0;
			end
			if (!held && sent >= 800) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					n = $urandom_range(1, 5);
					send_byte(8'($urandom), 1'b1);
					repeat (n - 1) send_byte(8'($urandom), 1'b0);
					aligned = 1'b0;
				end
				3, 4: begin
					n = $urandom_range(1, 8);
					repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
					aligned = 1'b0;
				end
				default: begin
					send_frame(pick_word(), pick_word(), $urandom_range(0, 9) == 0,
						$urandom_range(0, 9) == 0, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
					aligned = 1'b1;
				end
			endcase
		end
		rx_ch.valid <= 1'b0;

		@(posedge clk);
		waited = 0;
		while (pending != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			if (pending != 0)
				$error("%0d readings never returned", pending);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/hsfd_pkg.sv
design/hsfd_byte_if.sv
design/hsfd_res_if.sv
design/hsfd_frame_front.sv
design/hsfd_queue.sv
design/hsfd_convert_back.sv
design/humidity_sensor_frame_decoder_unit.sv
dv/hsfd_reading_checker.sv
dv/tb_top.sv
